// ===== rtl/drs_pkg.sv =====
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types, constants and helper functions of the dyad recency statistic.
// ----------------------------------------------------------------------------
`default_nettype none

package drs_pkg;

  // Sizing
  localparam int ACTORS    = 64;
  localparam int TIME_BITS = 32;
  localparam int PAIRS     = ACTORS * ACTORS;
  localparam int SLOT_W    = $clog2(PAIRS);
  localparam int AID_W     = $clog2(ACTORS);
  localparam int ID_W      = 6;
  localparam int ID_CNT    = 1 << ID_W;
  localparam int EVT_T_W   = 32;
  localparam int T_IN_W    = (TIME_BITS < EVT_T_W) ? TIME_BITS : EVT_T_W;
  localparam int STAT_W    = 48;

  // Reciprocal: round(2^16 / den), den = diff + 1, quotient below 2^17
  localparam int FRAC_BITS = 16;
  localparam int Q_BITS    = FRAC_BITS + 1;
  localparam int DEN_W     = TIME_BITS + 1;
  localparam int NUM_W     = ((TIME_BITS >= Q_BITS) ? TIME_BITS : Q_BITS) + 1;
  localparam int QCNT_W    = $clog2(Q_BITS);

  localparam logic [STAT_W-1:0] STAT_MAX_POS = {1'b0, {(STAT_W-1){1'b1}}};

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPOSE_KEY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_DIFFERENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_PAST_VALUE  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;     // write one zero entry, advance clear address
    logic capture;    // latch an accepted event
    logic rd_en;      // read the pair entry
    logic eval;       // evaluate the entry, update the table
    logic div_start;  // launch the reciprocal
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic sampled;
    logic need_div;
    logic div_done;
    logic out_free;
  } status_t;

  // Actor id modulo ACTORS, as a constant lookup over all id codes
  function automatic logic [AID_W-1:0] aid_mod(input logic [ID_W-1:0] id);
    logic [AID_W-1:0] r;
    r = '0;
    for (int v = 0; v < ID_CNT; v++) begin
      if (id == ID_W'(v)) begin
        r = AID_W'(v % ACTORS);
      end
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] pair_slot(input logic [AID_W-1:0] first,
                                                  input logic [AID_W-1:0] second);
    return SLOT_W'(SLOT_W'(first) * SLOT_W'(ACTORS) + SLOT_W'(second));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/drs_if.sv =====
// ----------------------------------------------------------------------------
// drs_if
// Channel interfaces: event input, result output and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface drs_evt_if;
  logic                       valid;
  logic                       ready;
  logic [drs_pkg::EVT_T_W-1:0] event_time;
  logic [drs_pkg::ID_W-1:0]    sender_id;
  logic [drs_pkg::ID_W-1:0]    target_id;
  logic                       is_sampled;
  logic                       is_control;

  modport source (output valid, event_time, sender_id, target_id, is_sampled, is_control,
                  input ready);
  modport sink   (input valid, event_time, sender_id, target_id, is_sampled, is_control,
                  output ready);
endinterface

interface drs_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [drs_pkg::STAT_W-1:0] statistic;
  logic                             order_error;

  modport source (output valid, statistic, order_error, input ready);
  modport sink   (input valid, statistic, order_error, output ready);
endinterface

interface drs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [drs_pkg::CFG_IDX_W-1:0]  index;
  logic [drs_pkg::STAT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/drs_ram.sv =====
// ----------------------------------------------------------------------------
// drs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/drs_recip_div.sv =====
// ----------------------------------------------------------------------------
// drs_recip_div
// Iterative restoring divider: round(2^16 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_recip_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [drs_pkg::DEN_W-1:0]    den_i,
  output logic                              done_o,
  output logic      [drs_pkg::Q_BITS-1:0]   quot_o
);

  localparam int DW = drs_pkg::DEN_W;
  localparam int QB = drs_pkg::Q_BITS;
  localparam int NW = drs_pkg::NUM_W;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [drs_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   den_q, den_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [QB-1:0]   num_q, num_d;
  logic [QB-1:0]   quot_q, quot_d;
  logic [NW-1:0]   numer;
  logic [DW:0]     trial;
  logic            fits;

  // Numerator carries the half-divisor for round-half-up
  assign numer = NW'(32'h0001_0000) + NW'(den_i >> 1);
  assign trial = {rem_q, num_q[QB-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    den_d  = den_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = drs_pkg::QCNT_W'(QB - 1);
      den_d  = den_i;
      // High part of the numerator is already below den
      rem_d  = DW'(numer >> QB);
      num_d  = numer[QB-1:0];
    end else if (busy_q) begin
      rem_d  = fits ? DW'(trial - {1'b0, den_q}) : DW'(trial);
      num_d  = {num_q[QB-2:0], 1'b0};
      quot_d = {quot_q[QB-2:0], fits};
      cnt_d  = cnt_q - drs_pkg::QCNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q  <= den_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/drs_datapath.sv =====
// ----------------------------------------------------------------------------
// drs_datapath
// Pair-time table, configuration registers, result logic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  drs_evt_if.sink                 evt_i,
  drs_res_if.source               res_o,
  drs_cfg_if.sink                 cfg_i,
  input  wire drs_pkg::cmd_t      cmd_i,
  output drs_pkg::status_t        status_o
);

  localparam int TB = drs_pkg::TIME_BITS;
  localparam int SW = drs_pkg::SLOT_W;
  localparam int OW = drs_pkg::STAT_W;

  // Configuration
  logic          transpose_q;
  logic          raw_q;
  logic [OW-1:0] no_past_q;

  // Captured event
  logic [TB-1:0] t_q;
  logic [SW-1:0] slot_q;
  logic          sampled_q;
  logic          control_q;

  // Table and clear sweep
  logic [SW-1:0] clr_addr_q;
  logic          ram_we;
  logic [SW-1:0] ram_waddr;
  logic [TB-1:0] ram_wdata;
  logic [TB-1:0] prev;

  // Evaluation
  logic          never;
  logic          late;
  logic [TB-1:0] diff;
  logic [63:0]   diff_wide;
  logic [OW-1:0] raw_stat;
  logic [OW-1:0] res_stat_d, res_stat_q;
  logic          res_err_q;
  logic          use_div_q;
  logic          div_done;
  logic [drs_pkg::Q_BITS-1:0] quot;

  // Output register
  logic          out_valid_q;
  logic [OW-1:0] out_stat_q;
  logic          out_err_q;

  logic [drs_pkg::AID_W-1:0] snd_aid;
  logic [drs_pkg::AID_W-1:0] tgt_aid;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b1;
      raw_q       <= 1'b0;
      no_past_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        drs_pkg::CFG_TRANSPOSE_KEY:  transpose_q <= cfg_i.data[0];
        drs_pkg::CFG_RAW_DIFFERENCE: raw_q       <= cfg_i.data[0];
        drs_pkg::CFG_NO_PAST_VALUE:  no_past_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign snd_aid = drs_pkg::aid_mod(evt_i.sender_id);
  assign tgt_aid = drs_pkg::aid_mod(evt_i.target_id);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      t_q       <= TB'(evt_i.event_time[drs_pkg::T_IN_W-1:0]);
      slot_q    <= transpose_q ? drs_pkg::pair_slot(snd_aid, tgt_aid)
                               : drs_pkg::pair_slot(tgt_aid, snd_aid);
      sampled_q <= evt_i.is_sampled;
      control_q <= evt_i.is_control;
    end
  end

  // Clear sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_addr_q <= clr_addr_q + SW'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_q;
    ram_wdata = t_q;
    if (cmd_i.clr_en) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else if (cmd_i.eval && !control_q) begin
      ram_we    = 1'b1;
    end
  end

  drs_ram #(
    .WIDTH (TB),
    .DEPTH (drs_pkg::PAIRS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (slot_q),
    .rdata_o (prev)
  );

  assign never     = (prev == '0);
  assign late      = (t_q < prev);
  assign diff      = t_q - prev;
  assign diff_wide = 64'(diff);
  assign raw_stat  = (|diff_wide[63:31]) ? drs_pkg::STAT_MAX_POS
                                         : {1'b0, diff_wide[30:0], 16'h0000};

  always_comb begin
    if (never) begin
      res_stat_d = no_past_q;
    end else if (late) begin
      res_stat_d = '0;
    end else begin
      res_stat_d = raw_stat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      res_stat_q <= res_stat_d;
      res_err_q  <= !never && late;
      use_div_q  <= !never && !late && !raw_q;
    end
  end

  drs_recip_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .den_i   (drs_pkg::DEN_W'(diff) + drs_pkg::DEN_W'(1)),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_stat_q <= use_div_q ? OW'(quot) : res_stat_q;
      out_err_q  <= res_err_q;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.statistic   = $signed(out_stat_q);
  assign res_o.order_error = out_err_q;

  assign status_o.clr_last = (clr_addr_q == SW'(drs_pkg::PAIRS - 1));
  assign status_o.sampled  = sampled_q;
  assign status_o.need_div = !never && !late && !raw_q;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || res_o.ready;

endmodule

`default_nettype wire

// ===== rtl/drs_ctrl.sv =====
// ----------------------------------------------------------------------------
// drs_ctrl
// Sequencer: clear sweep, event capture, table read, evaluate, divide, hand off.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               evt_valid_i,
  output logic                    evt_ready_o,
  input  wire drs_pkg::status_t   status_i,
  output drs_pkg::cmd_t           cmd_o
);

  drs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= drs_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drs_pkg::ST_CLEAR: begin
        if (status_i.clr_last) state_d = drs_pkg::ST_IDLE;
      end
      drs_pkg::ST_IDLE: begin
        if (evt_valid_i) state_d = drs_pkg::ST_READ;
      end
      drs_pkg::ST_READ: begin
        state_d = drs_pkg::ST_EVAL;
      end
      drs_pkg::ST_EVAL: begin
        if (!status_i.sampled) begin
          state_d = drs_pkg::ST_IDLE;
        end else if (status_i.need_div) begin
          state_d = drs_pkg::ST_DIVIDE;
        end else begin
          state_d = drs_pkg::ST_DONE;
        end
      end
      drs_pkg::ST_DIVIDE: begin
        if (status_i.div_done) state_d = drs_pkg::ST_DONE;
      end
      drs_pkg::ST_DONE: begin
        if (status_i.out_free) state_d = drs_pkg::ST_IDLE;
      end
      default: state_d = drs_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    evt_ready_o = 1'b0;
    unique case (state_q)
      drs_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
      end
      drs_pkg::ST_IDLE: begin
        evt_ready_o   = 1'b1;
        cmd_o.capture = evt_valid_i;
      end
      drs_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
      end
      drs_pkg::ST_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.div_start = status_i.sampled && status_i.need_div;
      end
      drs_pkg::ST_DIVIDE: ;
      drs_pkg::ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/dyad_recency_statistic_top.sv =====
// ----------------------------------------------------------------------------
// dyad_recency_statistic_top
// Recency statistic over a stream of relational events, keyed by actor pair.
// ----------------------------------------------------------------------------
// After reset the block sweeps all ACTORS*ACTORS entries of its pair-time
// table to zero, one entry a cycle, while evt_i.ready stays low; register
// writes are taken at any time. It then handles one event at a time. An event
// is captured in IDLE, its pair entry is read from the table RAM in READ, and
// the entry is evaluated in EVAL and rewritten unless the event is a control
// event; an event that gives no result then returns to IDLE. An event whose
// result is the no-past value, an order error or a raw difference loads the
// output register in DONE once that register is free. The inverse of
// difference plus one runs through an iterative divider in DIVIDE that yields
// one quotient bit a cycle, 17 bits, before DONE. Results wait in an output
// register, so a stalled result holds up the next event only when that event
// also finishes a result.
// Registers are written over cfg_i: index 0 transpose_key, 1 raw_difference,
// 2 no_past_value (signed Q32.16); write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module dyad_recency_statistic_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  drs_evt_if.sink   evt_i,
  drs_res_if.source res_o,
  drs_cfg_if.sink   cfg_i
);

  drs_pkg::cmd_t    cmd;
  drs_pkg::status_t status;

  // Sequence the clear sweep and each event transaction
  drs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the table, config and result; drive the output transaction
  drs_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt_i),
    .res_o    (res_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

`default_nettype wire

// ===== rtl/drs_checker.sv =====
// ----------------------------------------------------------------------------
// drs_checker
// Port-level assertions for the dyad recency statistic, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module drs_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [drs_pkg::STAT_W-1:0]  statistic_i,
  input wire logic                        order_error_i
);

  // Result held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(statistic_i)
                                    && $stable(order_error_i))
    else $error("result changed while stalled");

  // Order error forces a zero statistic
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && order_error_i |-> statistic_i == '0)
    else $error("order error with nonzero statistic");

  // One event in flight: no back-to-back accepts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("event accepted while previous one in flight");

  // Table clear blocks input right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !in_ready_i && !out_valid_i)
    else $error("input taken during table clear");

endmodule

bind dyad_recency_statistic_top drs_checker u_drs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (evt_i.valid),
  .in_ready_i    (evt_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .statistic_i   (res_o.statistic),
  .order_error_i (res_o.order_error)
);

`default_nettype wire

// ===== sim/dyad_recency_checker.sv =====
// ----------------------------------------------------------------------------
// dyad_recency_checker
// Watches the event, result and register channels of the recency block. It
// keeps its own pair-time table and register copies, works out the recency
// result of every sampled event at acceptance, and compares each result
// transaction field by field against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module dyad_recency_checker (
  input  logic clk_i,
  input  logic rst_ni,
  drs_evt_if   evt_i,
  drs_res_if   res_i,
  drs_cfg_if   cfg_i,
  output int   mismatch_count_o,
  output int   awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [drs_pkg::STAT_W-1:0] statistic;
    logic                       order_error;
  } recency_t;

  logic [drs_pkg::TIME_BITS-1:0] last_seen [drs_pkg::PAIRS];
  logic                          transpose_key;
  logic                          raw_difference;
  logic [drs_pkg::STAT_W-1:0]    no_past_value;
  recency_t                      awaited_q [$];
  int                            mismatches;

  task automatic report_mismatch(input string what,
                                 input logic [drs_pkg::STAT_W-1:0] want,
                                 input logic [drs_pkg::STAT_W-1:0] got);
    if (mismatches < 40) begin
      $display("[%0t] recency mismatch, %s: expected %h, got %h", $time, what, want, got);
    end
    mismatches++;
  endtask

  // Recency of a pair whose entry held prev, for an event at now
  function automatic recency_t recency_of(input logic [drs_pkg::TIME_BITS-1:0] prev,
                                          input logic [drs_pkg::TIME_BITS-1:0] now);
    recency_t    r;
    logic [63:0] gap;
    logic [63:0] den;
    r.statistic   = '0;
    r.order_error = 1'b0;
    if (prev == '0) begin
      r.statistic = no_past_value;
    end else if (now < prev) begin
      r.order_error = 1'b1;
    end else begin
      gap = 64'(now) - 64'(prev);
      if (raw_difference) begin
        r.statistic = (gap >= 64'h8000_0000) ? drs_pkg::STAT_MAX_POS
                                             : drs_pkg::STAT_W'(gap << 16);
      end else begin
        den         = gap + 64'd1;
        r.statistic = drs_pkg::STAT_W'((64'd65536 + den / 64'd2) / den);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [drs_pkg::AID_W-1:0]     first;
    logic [drs_pkg::AID_W-1:0]     second;
    logic [drs_pkg::SLOT_W-1:0]    slot;
    logic [drs_pkg::TIME_BITS-1:0] now;
    recency_t                      want;
    if (!rst_ni) begin
      foreach (last_seen[i]) last_seen[i] = '0;
      transpose_key  = 1'b1;
      raw_difference = 1'b0;
      no_past_value  = '0;
      awaited_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          drs_pkg::CFG_TRANSPOSE_KEY:  transpose_key  = cfg_i.data[0];
          drs_pkg::CFG_RAW_DIFFERENCE: raw_difference = cfg_i.data[0];
          drs_pkg::CFG_NO_PAST_VALUE:  no_past_value  = cfg_i.data;
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to an event of the same edge
      if (res_i.valid && res_i.ready) begin
        if (awaited_q.size() == 0) begin
          report_mismatch("result with none outstanding", '0, res_i.statistic);
        end else begin
          want = awaited_q.pop_front();
          if (res_i.statistic !== want.statistic) begin
            report_mismatch("statistic", want.statistic, res_i.statistic);
          end
          if (res_i.order_error !== want.order_error) begin
            report_mismatch("order_error", drs_pkg::STAT_W'(want.order_error),
                            drs_pkg::STAT_W'(res_i.order_error));
          end
        end
      end
      if (evt_i.valid && evt_i.ready) begin
        if (transpose_key) begin
          first  = drs_pkg::AID_W'(evt_i.sender_id % drs_pkg::ACTORS);
          second = drs_pkg::AID_W'(evt_i.target_id % drs_pkg::ACTORS);
        end else begin
          first  = drs_pkg::AID_W'(evt_i.target_id % drs_pkg::ACTORS);
          second = drs_pkg::AID_W'(evt_i.sender_id % drs_pkg::ACTORS);
        end
        slot = drs_pkg::SLOT_W'(drs_pkg::SLOT_W'(first) * drs_pkg::SLOT_W'(drs_pkg::ACTORS)
                                + drs_pkg::SLOT_W'(second));
        now  = drs_pkg::TIME_BITS'(evt_i.event_time[drs_pkg::T_IN_W-1:0]);
        if (evt_i.is_sampled) begin
          awaited_q.push_back(recency_of(last_seen[slot], now));
        end
        if (!evt_i.is_control) begin
          last_seen[slot] = now;
        end
      end
    end
    mismatch_count_o <= mismatches;
    awaited_o        <= awaited_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the dyad recency statistic block. A directed run
// covers first sightings, zero and unit gaps, rounding ties, order errors,
// control events, key transposition and saturation; random phases then sweep
// the registers through their extremes with repeating actor pairs, mostly
// rising timestamps and random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES    = 40;      // longer than the divider path
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 5;
  localparam int PHASE_EVENTS    = 160;
  localparam int PRESSURE_CYCLES = 400;
  localparam logic [drs_pkg::ID_W-1:0] CROWD [4] = '{6'd0, 6'd21, 6'd42, 6'd63};
  localparam logic [drs_pkg::STAT_W-1:0] STAT_MIN_NEG =
    {1'b1, {(drs_pkg::STAT_W-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_count;
  int   awaited;
  bit   pressure_arm;
  int   cycles;

  drs_evt_if evt ();
  drs_res_if res ();
  drs_cfg_if cfg ();

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dyad_recency_statistic_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  dyad_recency_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_i            (evt),
    .res_i            (res),
    .cfg_i            (cfg),
    .mismatch_count_o (mismatch_count),
    .awaited_o        (awaited)
  );

  // Offer one event and hold it until the transaction completes. Valid is
  // left high so a back-to-back event follows without a bubble.
  task automatic offer_event(input logic [drs_pkg::EVT_T_W-1:0] at,
                             input logic [drs_pkg::ID_W-1:0] from,
                             input logic [drs_pkg::ID_W-1:0] to, input bit sampled,
                             input bit control);
    evt.valid      <= 1'b1;
    evt.event_time <= at;
    evt.sender_id  <= from;
    evt.target_id  <= to;
    evt.is_sampled <= sampled;
    evt.is_control <= control;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
  endtask

  // Drop valid, let every outstanding result drain, then give the block time
  // to finish any event that produces no result.
  task automatic wait_idle();
    evt.valid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [drs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [drs_pkg::STAT_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
  endtask

  // Write all three registers back to back, then release the channel.
  task automatic program_regs(input bit transpose, input bit raw,
                              input logic [drs_pkg::STAT_W-1:0] no_past);
    cfg_write(drs_pkg::CFG_TRANSPOSE_KEY, drs_pkg::STAT_W'(transpose));
    cfg_write(drs_pkg::CFG_RAW_DIFFERENCE, drs_pkg::STAT_W'(raw));
    cfg_write(drs_pkg::CFG_NO_PAST_VALUE, no_past);
    cfg.valid <= 1'b0;
  endtask

  // Result side: random backpressure, plus one long hold-off once the random
  // phases are running so the output register fills and the input stalls.
  initial begin
    int  mode;
    int  span;
    int  held;
    bit  pressure_done;
    pressure_done = 1'b0;
    res.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (pressure_arm && !pressure_done) begin
        res.ready <= 1'b0;
        held = 0;
        while (held < PRESSURE_CYCLES) begin
          @(posedge clk_i);
          held++;
        end
        pressure_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 99);
        if (mode < 40) begin
          // stretch with no stall at all
          res.ready <= 1'b1;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end else if (mode < 80) begin
          res.ready <= 1'($urandom_range(0, 1));
          @(posedge clk_i);
        end else begin
          // mostly short stalls, now and then a long one
          res.ready <= 1'b0;
          span = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
          repeat (span) @(posedge clk_i);
        end
      end
    end
  end

  // Watchdog: the slowest correct run stays well below this
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int                              roll;
    int                              gap;
    logic [drs_pkg::EVT_T_W-1:0]     at;
    logic [drs_pkg::EVT_T_W-1:0]     stream_time;
    logic [drs_pkg::ID_W-1:0]        from;
    logic [drs_pkg::ID_W-1:0]        to;
    bit                              sampled;
    bit                              control;
    bit                              transpose;
    bit                              raw;
    logic [drs_pkg::STAT_W-1:0]      no_past;

    pressure_arm = 1'b0;
    rst_ni         <= 1'b0;
    evt.valid      <= 1'b0;
    evt.event_time <= '0;
    evt.sender_id  <= '0;
    evt.target_id  <= '0;
    evt.is_sampled <= 1'b0;
    evt.is_control <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.index      <= drs_pkg::CFG_TRANSPOSE_KEY;
    cfg.data       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset registers: sender-first key, inverse form, no-past zero.
    // The first event waits out the table clear after reset.
    offer_event(32'd100, 6'd0, 6'd0, 1'b1, 1'b0);         // pair never seen
    offer_event(32'd100, 6'd0, 6'd0, 1'b1, 1'b0);         // zero gap gives 1.0
    offer_event(32'd101, 6'd0, 6'd0, 1'b1, 1'b0);         // gap of one
    offer_event(32'd103, 6'd0, 6'd0, 1'b1, 1'b0);         // gap of two, rounds down
    offer_event(32'd50, 6'd0, 6'd0, 1'b1, 1'b1);          // order error, control
    offer_event(32'd103, 6'd0, 6'd0, 1'b1, 1'b0);         // control left entry alone
    offer_event(32'd200, 6'd63, 6'd62, 1'b0, 1'b0);       // store only
    offer_event(32'd300, 6'd62, 6'd63, 1'b1, 1'b0);       // reverse pair is separate
    offer_event(32'hFFFF_FFFF, 6'd63, 6'd62, 1'b1, 1'b0); // huge gap, inverse is zero
    offer_event(32'd0, 6'd5, 6'd6, 1'b0, 1'b0);           // zero time stored
    offer_event(32'd7, 6'd5, 6'd6, 1'b1, 1'b0);           // reads as never seen
    offer_event(32'd1, 6'd1, 6'd2, 1'b0, 1'b0);
    offer_event(32'd131072, 6'd1, 6'd2, 1'b1, 1'b0);      // exact half, rounds up

    // Directed, target-first key, raw form, no-past at the positive extreme
    wait_idle();
    program_regs(1'b0, 1'b1, drs_pkg::STAT_MAX_POS);
    offer_event(32'd103, 6'd0, 6'd0, 1'b1, 1'b0);         // raw zero gap
    offer_event(32'd10, 6'd3, 6'd4, 1'b0, 1'b0);
    offer_event(32'd20, 6'd4, 6'd3, 1'b1, 1'b0);          // transposed key unseen
    offer_event(32'd25, 6'd3, 6'd4, 1'b1, 1'b0);
    offer_event(32'd1, 6'd10, 6'd11, 1'b0, 1'b0);
    offer_event(32'h8000_0000, 6'd10, 6'd11, 1'b1, 1'b1); // largest gap below saturation
    offer_event(32'h8000_0001, 6'd10, 6'd11, 1'b1, 1'b0); // saturates
    offer_event(32'hFFFF_FFFF, 6'd10, 6'd11, 1'b1, 1'b0);
    offer_event(32'd5, 6'd10, 6'd11, 1'b1, 1'b1);         // order error in raw form
    offer_event(32'd9, 6'd63, 6'd0, 1'b1, 1'b0);

    // Random phases, each with its own register setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       begin transpose = 1'b1; raw = 1'b0; no_past = STAT_MIN_NEG; end
        1:       begin transpose = 1'b0; raw = 1'b1; no_past = drs_pkg::STAT_MAX_POS; end
        2:       begin
          transpose = 1'b1; raw = 1'b1; no_past = drs_pkg::STAT_W'({$urandom, $urandom});
        end
        3:       begin
          transpose = 1'b0; raw = 1'b0; no_past = drs_pkg::STAT_W'({$urandom, $urandom});
        end
        default: begin
          transpose = 1'($urandom_range(0, 1));
          raw       = 1'($urandom_range(0, 1));
          no_past   = '0;
        end
      endcase
      program_regs(transpose, raw, no_past);
      if (phase == 1) pressure_arm = 1'b1;
      stream_time = $urandom_range(1, 1000);

      for (int i = 0; i < PHASE_EVENTS; i++) begin
        // Timestamps mostly creep upward so pairs repeat with small gaps;
        // big jumps reach saturation, and a few go backward or to zero.
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          stream_time += $urandom_range(0, 3);
          at = stream_time;
        end else if (roll < 80) begin
          stream_time += $urandom_range(4, 70000);
          at = stream_time;
        end else if (roll < 85) begin
          stream_time += $urandom;
          at = stream_time;
        end else if (roll < 92) begin
          at = stream_time - $urandom_range(1, 500);
        end else if (roll < 95) begin
          at = '0;
        end else begin
          at = $urandom;
        end
        // a small crowd of actors keeps pairs recurring
        if ($urandom_range(0, 3) != 0) begin
          from = CROWD[$urandom_range(0, 3)];
          to   = CROWD[$urandom_range(0, 3)];
        end else begin
          from = drs_pkg::ID_W'($urandom_range(0, 63));
          to   = drs_pkg::ID_W'($urandom_range(0, 63));
        end
        sampled = ($urandom_range(0, 9) < 7);
        control = ($urandom_range(0, 6) == 0);
        offer_event(at, from, to, sampled, control);

        // every fourth block of 40 events runs with no gaps at all
        roll = $urandom_range(0, 99);
        if ((i / 40) % 4 == 1) gap = 0;
        else if (roll < 55) gap = 0;
        else if (roll < 85) gap = $urandom_range(1, 3);
        else if (roll < 95) gap = $urandom_range(4, 10);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
          evt.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_idle();
    if (mismatch_count == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
